/* rtl/pbmi_pkg.sv */
// Package with the shared constants and types of the periodic box correction block.
`default_nettype none
package pbmi_pkg;

	localparam int COORD_FRAC_BITS = 16;
	localparam int RECIP_FRAC_BITS = 24;
	localparam int PROD_SHIFT      = COORD_FRAC_BITS + RECIP_FRAC_BITS;

	localparam int DATA_W   = 32;
	localparam int LEN_W    = 31;
	localparam int RECIP_W  = 32;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_AXES = 3;
	localparam int AXIS_W   = 2;

	// Magnitude times reciprocal, then the cell count with one spare bit for rounding up.
	localparam int PROD_W  = DATA_W + RECIP_W;
	localparam int Q_W     = PROD_W - PROD_SHIFT + 1;
	localparam int DPROD_W = LEN_W + Q_W;

	localparam int NUM_STAGES = 5;

	localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(1) << COORD_FRAC_BITS;
	localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(1) << RECIP_FRAC_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_LEN_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RECIP_Z = 3'd5;

	localparam logic KIND_MIN_IMAGE = 1'b0;
	localparam logic KIND_WRAP      = 1'b1;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic [NUM_AXES-1:0][LEN_W-1:0]   len;
		logic [NUM_AXES-1:0][RECIP_W-1:0] recip;
	} box_cfg_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic                  trunc;
	} pipe_ctrl_t;

endpackage
`default_nettype wire

/* rtl/pbmi_vec_if.sv */
// Input channel carrying one vector and its correction kind.
`default_nettype none
interface pbmi_vec_if import pbmi_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic signed [DATA_W-1:0] in_x;
	logic signed [DATA_W-1:0] in_y;
	logic signed [DATA_W-1:0] in_z;

	modport source (output valid, kind, in_x, in_y, in_z, input ready);
	modport sink (input valid, kind, in_x, in_y, in_z, output ready);
endinterface
`default_nettype wire

/* rtl/pbmi_res_if.sv */
// Output channel carrying one corrected vector.
`default_nettype none
interface pbmi_res_if import pbmi_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] out_x;
	logic signed [DATA_W-1:0] out_y;
	logic signed [DATA_W-1:0] out_z;

	modport source (output valid, out_x, out_y, out_z, input ready);
	modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface
`default_nettype wire

/* rtl/pbmi_cfg_if.sv */
// Configuration write channel: register index and write data.
`default_nettype none
interface pbmi_cfg_if import pbmi_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/pbmi_cfg.sv */
// Box length and reciprocal registers with their write decode.
`default_nettype none
module pbmi_cfg import pbmi_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	pbmi_cfg_if.sink  cfg,
	output box_cfg_t  box
);

	box_cfg_t box_q;

	assign cfg.ready = 1'b1;
	assign box       = box_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				box_q.len[a]   <= LEN_RESET;
				box_q.recip[a] <= RECIP_RESET;
			end
		end else if (cfg.valid) begin
			// Writes to indexes past the last register are dropped.
			unique case (cfg.index)
				REG_LEN_X:   box_q.len[AXIS_X]   <= cfg.data[LEN_W-1:0];
				REG_LEN_Y:   box_q.len[AXIS_Y]   <= cfg.data[LEN_W-1:0];
				REG_LEN_Z:   box_q.len[AXIS_Z]   <= cfg.data[LEN_W-1:0];
				REG_RECIP_X: box_q.recip[AXIS_X] <= cfg.data[RECIP_W-1:0];
				REG_RECIP_Y: box_q.recip[AXIS_Y] <= cfg.data[RECIP_W-1:0];
				REG_RECIP_Z: box_q.recip[AXIS_Z] <= cfg.data[RECIP_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/pbmi_lane.sv */
// One axis of the correction pipeline: magnitude, scale, round, multiply back, subtract.
`default_nettype none
module pbmi_lane import pbmi_pkg::*; (
	input  wire logic               clk,
	input  wire pipe_ctrl_t         ctrl,
	input  wire logic [DATA_W-1:0]  v,
	input  wire logic [LEN_W-1:0]   len,
	input  wire logic [RECIP_W-1:0] recip,
	output logic      [DATA_W-1:0]  res
);

	logic [DATA_W-1:0]  v_s1, v_s2, v_s3, v_s4;
	logic               neg_s1, neg_s2, neg_s3, neg_s4;
	logic [DATA_W-1:0]  mag_s1;
	logic [PROD_W-1:0]  prod_s2;
	logic [Q_W-1:0]     q_s3;
	logic [DATA_W-1:0]  delta_s4;
	logic [DATA_W-1:0]  res_s5;
	logic               round_up;
	logic [DPROD_W-1:0] dprod;

	// Unless trunc is set, round half to even on the exact product: the top remainder
	// bit is the half, and a tie rounds up only when the integer part is odd.
	always_comb begin
		round_up = !ctrl.trunc && prod_s2[PROD_SHIFT-1]
			&& ((|prod_s2[PROD_SHIFT-2:0]) || prod_s2[PROD_SHIFT]);
	end

	assign dprod = DPROD_W'(len) * DPROD_W'(q_s3);
	assign res   = res_s5;

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			v_s1   <= v;
			neg_s1 <= v[DATA_W-1];
			mag_s1 <= v[DATA_W-1] ? (~v + 1'b1) : v;
		end
		if (ctrl.en[1]) begin
			v_s2    <= v_s1;
			neg_s2  <= neg_s1;
			prod_s2 <= PROD_W'(mag_s1) * PROD_W'(recip);
		end
		if (ctrl.en[2]) begin
			v_s3   <= v_s2;
			neg_s3 <= neg_s2;
			q_s3   <= Q_W'(prod_s2[PROD_W-1:PROD_SHIFT]) + Q_W'(round_up);
		end
		if (ctrl.en[3]) begin
			v_s4     <= v_s3;
			neg_s4   <= neg_s3;
			delta_s4 <= dprod[DATA_W-1:0];
		end
		if (ctrl.en[4]) begin
			res_s5 <= neg_s4 ? (v_s4 + delta_s4) : (v_s4 - delta_s4);
		end
	end

endmodule
`default_nettype wire

/* rtl/periodic_box_min_image.sv */
// Top level of the periodic box correction: configuration, three axis lanes, flow control.
//
//   port   dir   payload                      role
//   cfg    in    index, data                  box length / reciprocal register writes
//   vec    in    kind, in_x, in_y, in_z       vector to correct
//   res    out   out_x, out_y, out_z          corrected vector
//
// One vector per cycle unless a stall on res has filled every stage.
// Each lane registers its stages in order: magnitude, scale, round, multiply back, subtract.
// Reset clears the stage valid bits and loads unit length and unit reciprocal.
// A stall on res holds the last stage; bubbles further up still fill, so vec stays
// ready until every stage holds an item.
`default_nettype none
module periodic_box_min_image import pbmi_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pbmi_cfg_if.sink   cfg,
	pbmi_vec_if.sink   vec,
	pbmi_res_if.source res
);

	box_cfg_t              box;
	pipe_ctrl_t            ctrl;
	logic [NUM_STAGES-1:0] vld_q;
	logic                  kind_s1, kind_s2;
	logic [NUM_AXES-1:0][DATA_W-1:0] lane_in;
	logic [NUM_AXES-1:0][DATA_W-1:0] lane_res;

	pbmi_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.box    (box)
	);

	// A stage loads when it is empty or when the stage after it moves on.
	always_comb begin
		ctrl.en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || res.ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			ctrl.en[k] = !vld_q[k] || ctrl.en[k+1];
		end
		ctrl.trunc = (kind_s2 == KIND_WRAP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctrl.en[0]) begin
				vld_q[0] <= vec.valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (ctrl.en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			kind_s1 <= vec.kind;
		end
		if (ctrl.en[1]) begin
			kind_s2 <= kind_s1;
		end
	end

	assign lane_in[AXIS_X] = vec.in_x;
	assign lane_in[AXIS_Y] = vec.in_y;
	assign lane_in[AXIS_Z] = vec.in_z;

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		pbmi_lane u_lane (
			.clk   (clk),
			.ctrl  (ctrl),
			.v     (lane_in[a]),
			.len   (box.len[a]),
			.recip (box.recip[a]),
			.res   (lane_res[a])
		);
	end

	assign vec.ready = ctrl.en[0];
	assign res.valid = vld_q[NUM_STAGES-1];
	assign res.out_x = lane_res[AXIS_X];
	assign res.out_y = lane_res[AXIS_Y];
	assign res.out_z = lane_res[AXIS_Z];

	// A downstream that takes results never stalls the input.
	a_ready_flows: assert property (@(posedge clk) disable iff (!arst_n)
		res.ready |-> vec.ready)
		else $error("input stalled while output is ready");

	// An item waiting in a stage is not lost while the next stage is blocked.
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[3] && !ctrl.en[4] |=> vld_q[3])
		else $error("stage four item dropped during stall");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] && !ctrl.en[1] |=> vld_q[0])
		else $error("stage one item dropped during stall");

	// A transfer on the input always lands in the first stage.
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		vec.valid && vec.ready |=> vld_q[0])
		else $error("accepted vector not captured");

endmodule
`default_nettype wire

/* tb/pbmi_checker.sv */
// Checker for the periodic box correction: tracks the box registers, predicts and compares results.
`default_nettype none
module pbmi_checker import pbmi_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	pbmi_cfg_if       cfg,
	pbmi_vec_if       vec,
	pbmi_res_if       res,
	output int        errors,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [PROD_SHIFT-1:0] HALF_CELL = PROD_SHIFT'(1) << (PROD_SHIFT - 1);

	typedef struct packed {
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] z;
	} image_t;

	logic [LEN_W-1:0]   box_len   [NUM_AXES];
	logic [RECIP_W-1:0] box_recip [NUM_AXES];
	image_t             pending_images [$];
	int                 mismatch_count = 0;

	assign errors      = mismatch_count;
	assign outstanding = pending_images.size();

	// The cell count is formed from the magnitude, so rounding is symmetric about zero.
	function automatic logic [DATA_W-1:0] fold_component(input logic [DATA_W-1:0] v,
			input logic [LEN_W-1:0] len, input logic [RECIP_W-1:0] recip, input logic trunc);
		logic                     neg;
		logic [DATA_W:0]          mag;
		logic [PROD_W-1:0]        prod;
		logic [PROD_W-PROD_SHIFT:0] cells;
		logic [PROD_SHIFT-1:0]    frac;
		logic [DATA_W-1:0]        shift;
		neg   = v[DATA_W-1];
		mag   = neg ? ((DATA_W+1)'(1) << DATA_W) - {1'b0, v} : {1'b0, v};
		prod  = PROD_W'(mag) * PROD_W'(recip);
		cells = (PROD_W-PROD_SHIFT+1)'(prod >> PROD_SHIFT);
		frac  = prod[PROD_SHIFT-1:0];
		if (!trunc && (frac > HALF_CELL || (frac == HALF_CELL && cells[0])))
			cells = cells + 1'b1;
		shift = DATA_W'(64'(len) * 64'(cells));
		return neg ? v + shift : v - shift;
	endfunction

	task automatic report(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		image_t oldest;
		image_t fresh;
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				box_len[a]   <= LEN_RESET;
				box_recip[a] <= RECIP_RESET;
			end
		end else begin
			if (res.valid && res.ready) begin
				if (pending_images.size() == 0) begin
					report("result with no vector outstanding", res.out_x, '0);
				end else begin
					oldest = pending_images.pop_front();
					if (res.out_x !== oldest.x)
						report("out_x", res.out_x, oldest.x);
					if (res.out_y !== oldest.y)
						report("out_y", res.out_y, oldest.y);
					if (res.out_z !== oldest.z)
						report("out_z", res.out_z, oldest.z);
				end
			end
			if (vec.valid && vec.ready) begin
				fresh.x = fold_component(vec.in_x, box_len[AXIS_X], box_recip[AXIS_X],
					vec.kind == KIND_WRAP);
				fresh.y = fold_component(vec.in_y, box_len[AXIS_Y], box_recip[AXIS_Y],
					vec.kind == KIND_WRAP);
				fresh.z = fold_component(vec.in_z, box_len[AXIS_Z], box_recip[AXIS_Z],
					vec.kind == KIND_WRAP);
				pending_images.push_back(fresh);
			end
			// Bits above a register's width are dropped; unknown indexes change nothing.
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				REG_LEN_X:   box_len[AXIS_X]   <= cfg.data[LEN_W-1:0];
				REG_LEN_Y:   box_len[AXIS_Y]   <= cfg.data[LEN_W-1:0];
				REG_LEN_Z:   box_len[AXIS_Z]   <= cfg.data[LEN_W-1:0];
				REG_RECIP_X: box_recip[AXIS_X] <= cfg.data;
				REG_RECIP_Y: box_recip[AXIS_Y] <= cfg.data;
				REG_RECIP_Z: box_recip[AXIS_Z] <= cfg.data;
				default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

/* tb/tb.sv */
// Top of the periodic box correction testbench: clock, reset, stimulus, receiver stalls, verdict.
`default_nettype none
module tb import pbmi_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BOX_SETTINGS   = 12;
	localparam int VECTORS_PER_BOX = 120;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam logic [CFG_IDX_W-1:0] LEN_REG   [NUM_AXES] = '{REG_LEN_X, REG_LEN_Y, REG_LEN_Z};
	localparam logic [CFG_IDX_W-1:0] RECIP_REG [NUM_AXES] =
		'{REG_RECIP_X, REG_RECIP_Y, REG_RECIP_Z};

	// Unit box: ties at half cells, both signs, and the ends of the range.
	localparam logic [DATA_W-1:0] PROBES [7][NUM_AXES] = '{
		'{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF},
		'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000},
		'{32'h0000_8000, 32'h0001_8000, 32'h0002_8000},
		'{32'hFFFF_8000, 32'hFFFE_8000, 32'hFFFD_8000},
		'{32'h0000_8001, 32'h0000_7FFF, 32'h7FFF_8000},
		'{32'h8000_8000, 32'hFFFF_0000, 32'h8000_0001},
		'{32'hFFFF_7FFF, 32'h7FFE_8000, 32'h0000_0000}
	};

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_DENSE, RX_HOLD} rx_mode_t;

	logic clk;
	logic arst_n;
	int   errors;
	int   outstanding;
	int   burst_left;

	logic [LEN_W-1:0]   box_len   [NUM_AXES];
	logic [RECIP_W-1:0] box_recip [NUM_AXES];

	pbmi_cfg_if cfg_ch ();
	pbmi_vec_if vec_ch ();
	pbmi_res_if res_ch ();

	periodic_box_min_image DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.vec    (vec_ch),
		.res    (res_ch)
	);

	pbmi_checker check_u (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.vec         (vec_ch),
		.res         (res_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// About 1500 vectors; even with the longest gaps and hold-offs the run stays far
	// below this bound.
	initial begin
		#(4_000_000);
		$display("tb: failure");
		$finish;
	end

	// Starts at a falling edge; returns at one after the transfer, later when a burst ends.
	task automatic offer_vector(input logic kind, input logic [DATA_W-1:0] x,
			input logic [DATA_W-1:0] y, input logic [DATA_W-1:0] z);
		vec_ch.valid <= 1'b1;
		vec_ch.kind  <= kind;
		vec_ch.in_x  <= x;
		vec_ch.in_y  <= y;
		vec_ch.in_z  <= z;
		@(posedge clk);
		while (!vec_ch.ready)
			@(posedge clk);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			vec_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(0, 20);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Style 0 is a consistent box, 1 a power-of-two box, 2 an unrelated pair, 3 the extremes.
	task automatic pick_axis(input int style, output logic [LEN_W-1:0] len,
			output logic [RECIP_W-1:0] recip);
		int s;
		case (style)
		0: begin
			len   = LEN_W'($urandom_range(300, 32'h00FF_FFFF));
			recip = RECIP_W'((64'd1 << PROD_SHIFT) / 64'(len));
		end
		1: begin
			s     = $urandom_range(9, 30);
			len   = LEN_W'(1) << s;
			recip = RECIP_W'((64'd1 << PROD_SHIFT) >> s);
		end
		2: begin
			len   = LEN_W'($urandom);
			recip = $urandom;
		end
		default: begin
			case ($urandom_range(0, 2))
			0: len = '0;
			1: len = LEN_W'(1);
			default: len = '1;
			endcase
			case ($urandom_range(0, 2))
			0: recip = '0;
			1: recip = RECIP_W'(1);
			default: recip = '1;
			endcase
		end
		endcase
	endtask

	// A magnitude of an odd multiple of 2^(39-t), t the trailing zeros of recip, lands
	// exactly on a half cell.
	function automatic logic [DATA_W-1:0] half_cell_value(input logic [RECIP_W-1:0] recip);
		int           tz;
		longint       odd;
		logic [DATA_W:0] mag;
		tz = 0;
		while (tz < RECIP_W && !recip[tz])
			tz++;
		if (tz < 8 || tz >= RECIP_W)
			return $urandom;
		odd = 2 * longint'($urandom_range(0, ((1 << (tz - 8)) - 1) / 2)) + 1;
		mag = (DATA_W+1)'(odd << (PROD_SHIFT - 1 - tz));
		if (mag[DATA_W-1] || $urandom_range(0, 1))
			return DATA_W'(-mag);
		return DATA_W'(mag);
	endfunction

	function automatic logic [DATA_W-1:0] pick_component(input int axis);
		longint cell_idx;
		longint offset;
		case ($urandom_range(0, 9))
		0, 1, 2: return $urandom;
		3, 4, 5: begin
			cell_idx = longint'($urandom_range(0, 16)) - 8;
			offset   = longint'($urandom_range(0, box_len[axis]));
			if ($urandom_range(0, 1))
				offset = -offset;
			return DATA_W'(cell_idx * longint'(box_len[axis]) + offset);
		end
		6, 7: return half_cell_value(box_recip[axis]);
		8: begin
			case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h0000_8000;
			default: return 32'hFFFF_8000;
			endcase
		end
		default: return DATA_W'(int'($urandom_range(0, 2 * (1 << 20))) - (1 << 20));
		endcase
	endfunction

	// The first stretch after reset is a long hold-off, so the directed vectors back up
	// through the pipeline and the input has to stall.
	initial begin : receiver
		rx_mode_t mode;
		int       span;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		repeat (60)
			@(negedge clk);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 4));
			span = $urandom_range(20, 200);
			repeat (span) begin
				case (mode)
				RX_OPEN:   res_ch.ready <= 1'b1;
				RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
				RX_DENSE:  res_ch.ready <= ($urandom_range(0, 3) != 0);
				default:   res_ch.ready <= 1'b0;
				endcase
				@(negedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [LEN_W-1:0]   len;
		logic [RECIP_W-1:0] recip;
		int                 style;
		int                 waited;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data  = '0;
		vec_ch.valid = 1'b0;
		vec_ch.kind  = KIND_MIN_IMAGE;
		vec_ch.in_x  = '0;
		vec_ch.in_y  = '0;
		vec_ch.in_z  = '0;
		arst_n       = 1'b0;
		for (int a = 0; a < NUM_AXES; a++) begin
			box_len[a]   = LEN_RESET;
			box_recip[a] = RECIP_RESET;
		end
		repeat (7)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		burst_left = 2 * $size(PROBES) + 1;
		foreach (PROBES[i]) begin
			offer_vector(KIND_MIN_IMAGE, PROBES[i][0], PROBES[i][1], PROBES[i][2]);
			offer_vector(KIND_WRAP, PROBES[i][0], PROBES[i][1], PROBES[i][2]);
		end
		vec_ch.valid <= 1'b0;

		for (int phase = 0; phase < BOX_SETTINGS; phase++) begin
			// Registers change only with the pipeline empty.
			@(negedge clk);
			while (outstanding != 0)
				@(negedge clk);
			if (phase == 0 || $urandom_range(0, 3) == 0) begin
				write_reg(REG_SPARE_6, $urandom);
				write_reg(REG_SPARE_7, $urandom);
			end
			for (int a = 0; a < NUM_AXES; a++) begin
				if (phase == 0) begin
					// Largest length, zero length and the smallest nonzero length against extreme reciprocals.
					len   = (a == 0) ? '1 : (a == 1) ? '0 : LEN_W'(1);
					recip = (a == 2) ? '0 : '1;
				end else begin
					case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: style = 0;
					5, 6:          style = 1;
					7, 8:          style = 2;
					default:       style = 3;
					endcase
					pick_axis(style, len, recip);
				end
				box_len[a]   = len;
				box_recip[a] = recip;
				write_reg(LEN_REG[a], {1'($urandom_range(0, 1)), len});
				write_reg(RECIP_REG[a], recip);
			end
			cfg_ch.valid <= 1'b0;
			for (int n = 0; n < VECTORS_PER_BOX; n++)
				offer_vector(1'($urandom_range(0, 1)), pick_component(AXIS_X),
					pick_component(AXIS_Y), pick_component(AXIS_Z));
			vec_ch.valid <= 1'b0;
		end

		@(negedge clk);
		waited = 0;
		while (outstanding != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (4 * NUM_STAGES)
			@(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
